>>> design/masm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// masm_pkg
// Shared types and constants of the multiport address slot manager.
// ============================================================================
package masm_pkg;

    // Slot count bounds
    localparam int SLOT_COUNT_DEF = 2;
    localparam int SLOT_COUNT_MAX = 1 << 4;

    // Field widths
    localparam int ADDR_W = 48;
    localparam int PORT_W = 9;

    // Action codes
    localparam logic ACT_JOIN  = 1'b0;
    localparam logic ACT_LEAVE = 1'b1;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Request payload
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] group_address;
    } t_req;

    // Response payload
    typedef struct packed {
        t_status status;
        logic    slot_used;
        logic    enabled_after;
    } t_rsp;

endpackage

>>> design/masm_slot_table.sv
`timescale 1ns / 1ps
// ============================================================================
// masm_slot_table
// Slot storage, enable flag and the combinational join/leave update logic.
// ============================================================================
module masm_slot_table #(
    parameter int SLOT_COUNT = masm_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  masm_pkg::t_req             i_req,
    input  logic [masm_pkg::PORT_W-1:0] i_port_vector,
    output masm_pkg::t_rsp             o_rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                        r_enable;
    logic                        n_enable;
    logic [masm_pkg::ADDR_W-1:0] r_addr  [SLOT_COUNT];
    logic [masm_pkg::ADDR_W-1:0] n_addr  [SLOT_COUNT];
    logic [masm_pkg::PORT_W-1:0] r_ports [SLOT_COUNT];
    logic [masm_pkg::PORT_W-1:0] n_ports [SLOT_COUNT];

    // Next state and response for the current request
    always_comb begin
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        logic             occ_found;
        logic [IDX_W-1:0] occ_idx;
        logic             slot0_occ;

        n_enable = r_enable;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            n_addr[k]  = r_addr[k];
            n_ports[k] = r_ports[k];
        end
        o_rsp = '{status: masm_pkg::ST_OK, slot_used: 1'b0, enabled_after: r_enable};

        // Lowest free slot and lowest matching slot (scan high to low)
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (r_ports[k] == '0) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
            if (r_ports[k] == i_port_vector && r_addr[k] == i_req.group_address) begin
                match_found = 1'b1;
                match_idx   = IDX_W'(k);
            end
        end

        // Lowest occupied slot above slot 0 once the matched vector is cleared
        occ_found = 1'b0;
        occ_idx   = '0;
        for (int k = SLOT_COUNT - 1; k >= 1; k--) begin
            if (r_ports[k] != '0 && match_idx != IDX_W'(k)) begin
                occ_found = 1'b1;
                occ_idx   = IDX_W'(k);
            end
        end
        slot0_occ = (r_ports[0] != '0) && (match_idx != '0);

        if (i_valid) begin
            if (i_req.action == masm_pkg::ACT_JOIN) begin
                if (!r_enable) begin
                    // first join: claim slot 0, drop everything else
                    n_enable   = 1'b1;
                    n_addr[0]  = i_req.group_address;
                    n_ports[0] = i_port_vector;
                    for (int k = 1; k < SLOT_COUNT; k++) begin
                        n_ports[k] = '0;
                    end
                end else if (free_found) begin
                    n_addr[free_idx]  = i_req.group_address;
                    n_ports[free_idx] = i_port_vector;
                    o_rsp.slot_used   = free_idx[0];
                end else begin
                    o_rsp.status = masm_pkg::ST_FULL;
                end
            end else begin
                if (match_found) begin
                    n_ports[match_idx] = '0;
                    o_rsp.slot_used    = match_idx[0];
                    // compact into slot 0 when it went empty, or clear the enable flag when no slot is left
                    if (!slot0_occ) begin
                        if (occ_found) begin
                            n_addr[0]        = r_addr[occ_idx];
                            n_ports[0]       = r_ports[occ_idx];
                            n_ports[occ_idx] = '0;
                        end else begin
                            n_enable = 1'b0;
                        end
                    end
                end else begin
                    o_rsp.status = masm_pkg::ST_NOT_FOUND;
                end
            end
            o_rsp.enabled_after = n_enable;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_ports[k] <= '0;
                r_addr[k]  <= '0;
            end
        end else begin
            r_enable <= n_enable;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_ports[k] <= n_ports[k];
                r_addr[k]  <= n_addr[k];
            end
        end
    end

    // Checks
    a_join_sets_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_req.action == masm_pkg::ACT_JOIN && o_rsp.status == masm_pkg::ST_OK)
        |=> r_enable)
        else $error("enable flag clear after successful join");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> ($stable(r_enable) && $stable(r_ports[0])))
        else $error("state changed without a request");

    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_rsp.status != masm_pkg::ST_OK)
        |=> ($stable(r_enable) && $stable(r_ports[0]) && $stable(r_addr[0])))
        else $error("state changed on failed request");

    a_disable_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enable && !n_enable) |=> (r_ports[0] == '0))
        else $error("flag cleared while slot 0 occupied");

endmodule

>>> design/multiport_address_slot_manager.sv
`timescale 1ns / 1ps
// ============================================================================
// multiport_address_slot_manager
// Join/leave manager for a small table of multiport group address slots.
// ============================================================================
// A request is taken whenever start is high; busy never rises, so one request
// can be issued every cycle. Each request returns exactly one response through
// the request register and then the response register, shown for a single
// cycle with o_rsp_valid high; the receiver cannot stall it. All slots are
// compared and updated together by the table logic, and a following request
// sees the updated table. The port vector register is written through the
// configuration channel, which is always ready.
module multiport_address_slot_manager #(
    parameter int SLOT_COUNT = masm_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  masm_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    output masm_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [masm_pkg::PORT_W-1:0] i_cfg_data
);

    logic                        r_req_valid;
    masm_pkg::t_req              r_req;
    logic [masm_pkg::PORT_W-1:0] r_port_vector;
    logic                        r_rsp_valid;
    masm_pkg::t_rsp              r_rsp;
    masm_pkg::t_rsp              rsp_next;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Request and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid   <= 1'b0;
            r_port_vector <= '0;
        end else begin
            r_req_valid <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) begin
                r_port_vector <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // Slot table
    masm_slot_table #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_req_valid),
        .i_req         (r_req),
        .i_port_vector (r_port_vector),
        .o_rsp         (rsp_next)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_rsp <= rsp_next;
        end
    end

    // Checks
    a_one_rsp_per_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |=> o_rsp_valid)
        else $error("request produced no response");

    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(r_req_valid))
        else $error("response without request");

    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != masm_pkg::ST_OK) |-> !o_rsp.slot_used)
        else $error("slot reported on failed request");

endmodule
